>>> hdl/decimal_string_to_float_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the decimal string to float converter
// Both macros sample on clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_STRING_TO_FLOAT_TOP_ASSERT_SVH
`define DECIMAL_STRING_TO_FLOAT_TOP_ASSERT_SVH

// Same-cycle implication.
`define DSF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dsf assertion failed");

// Next-cycle implication.
`define DSF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsf assertion failed");

`endif

>>> hdl/dsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsf_pkg
// Constants, status codes and power-of-ten tables for the converter.
// ----------------------------------------------------------------------------
package dsf_pkg;

    localparam int MAX_SIG_DIGITS_DEF = 8;
    localparam int OFFSET_BITS_DEF    = 16;

    // Mantissa register width: holds up to nine decimal digits
    localparam int MANT_W = 30;
    localparam int SIG_W  = 24;
    localparam int POS_N  = 39;
    localparam int NEG_N  = 38;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UE    = 8'h45;
    localparam logic [7:0] CH_LE    = 8'h65;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UI    = 8'h49;
    localparam logic [7:0] CH_LI    = 8'h69;
    localparam logic [7:0] CH_UN    = 8'h4E;
    localparam logic [7:0] CH_LN    = 8'h6E;

    localparam logic [31:0] F32_INF = 32'h7F80_0000;

    // Correctly rounded binary32 of 10^k or 10^-k, evaluated at elaboration
    function automatic logic [31:0] pow10_bits(input int k, input bit neg);
        logic [255:0] den;
        logic [255:0] q;
        logic [255:0] rem;
        logic [23:0]  sig;
        logic         g;
        logic         st;
        logic [24:0]  r;
        int           p;
        int           e;
        int           i;
        int           sc;
        den = 256'd1;
        for (i = 0; i < k; i++)
        begin
            den = den * 256'd10;
        end
        q   = '0;
        rem = '0;
        sc  = 0;
        if (neg)
        begin
            // long division of 2^200 by 10^k
            sc = -200;
            for (i = 200; i >= 0; i--)
            begin
                rem = {rem[254:0], 1'(i == 200)};
                if (rem >= den)
                begin
                    rem  = rem - den;
                    q[i] = 1'b1;
                end
            end
        end
        else
        begin
            q = den;
        end
        p = 0;
        for (i = 0; i < 256; i++)
        begin
            if (q[i])
            begin
                p = i;
            end
        end
        if (p <= 23)
        begin
            sig = 24'(q << (23 - p));
            g   = 1'b0;
            st  = (rem != '0);
        end
        else
        begin
            sig = 24'(q >> (p - 23));
            g   = q[p - 24];
            st  = ((q & ((256'd1 << (p - 24)) - 256'd1)) != '0) || (rem != '0);
        end
        r = {1'b0, sig} + 25'(g & (st | sig[0]));
        e = 127 + p + sc;
        if (r[24])
        begin
            e = e + 1;
            r = r >> 1;
        end
        return {1'b0, 8'(e), r[22:0]};
    endfunction

    function automatic logic [POS_N*32-1:0] build_pos();
        logic [POS_N*32-1:0] t;
        int                  i;
        t = '0;
        for (i = 0; i < POS_N; i++)
        begin
            t[i*32 +: 32] = pow10_bits(i, 1'b0);
        end
        return t;
    endfunction

    function automatic logic [NEG_N*32-1:0] build_neg();
        logic [NEG_N*32-1:0] t;
        int                  i;
        t = '0;
        for (i = 0; i < NEG_N; i++)
        begin
            t[i*32 +: 32] = pow10_bits(i, 1'b1);
        end
        return t;
    endfunction

    localparam logic [POS_N*32-1:0] POS_TAB = build_pos();
    localparam logic [NEG_N*32-1:0] NEG_TAB = build_neg();

endpackage

>>> hdl/decimal_string_to_float_top.sv
`timescale 1ns / 1ps
// Sequence: characters are scanned as they arrive; at the end of the number
//   come a decide step, a normalise step that shifts the leading one up bit by
//   bit, a rounding step and one or two multiplies, each with its own rounding.
// Throughput: one character per cycle, no input during conversion or while a
//   result waits. The shared 24x24 multiplier and normaliser run while input is held.
// Reset: asynchronous, active low; returns to the start of a string.
// ----------------------------------------------------------------------------
// decimal_string_to_float_top
// Character-serial decimal to binary32 converter with a shared multiplier.
// ----------------------------------------------------------------------------
`include "decimal_string_to_float_top_assert.svh"

module decimal_string_to_float_top #(
    parameter int MAX_SIG_DIGITS = dsf_pkg::MAX_SIG_DIGITS_DEF,
    parameter int OFFSET_BITS    = dsf_pkg::OFFSET_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        ch_valid,
    output logic        ch_stall,
    input  logic [7:0]  ch,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [31:0] result_bits,
    output logic [15:0] end_offset,
    output logic [1:0]  status
);
    import dsf_pkg::*;

    localparam int SH_W = $clog2(MANT_W);
    localparam logic [OFFSET_BITS-1:0] POS_MAX  = '1;
    localparam logic [3:0]             SIG_LIM  = 4'(MAX_SIG_DIGITS);
    localparam logic [8:0]             CVT_BIAS = 9'(127 + MANT_W - 1);
    localparam logic signed [15:0]     DEC_MIN  = 16'sh8000;
    localparam logic signed [15:0]     DEC_MAX  = 16'sh7FFF;

    typedef enum logic [2:0] {
        S_SCAN, S_PREP, S_NORM, S_CVT, S_MUL, S_RND
    } state_t;

    typedef enum logic [2:0] {
        PH_SPACES, PH_AFTER_SIGN, PH_INF, PH_MANT,
        PH_EXP_START, PH_EXP_SIGN, PH_EXP_DIGITS, PH_DONE
    } phase_t;

    state_t                  state_reg, state_next;
    phase_t                  phase_reg, phase_next;
    logic [MANT_W-1:0]       mant_reg, mant_next;
    logic [3:0]              sig_cnt_reg, sig_cnt_next;
    logic signed [15:0]      dec_exp_reg, dec_exp_next;
    logic                    neg_reg, neg_next;
    logic                    point_reg, point_next;
    logic [9:0]              exp_dig_reg, exp_dig_next;
    logic                    exp_neg_reg, exp_neg_next;
    logic [OFFSET_BITS-1:0]  pos_reg, pos_next;
    logic [1:0]              inf_reg, inf_next;
    logic                    term_reg, term_next;
    logic                    out_valid_reg, out_valid_next;
    logic [31:0]             bits_reg, bits_next;
    logic [15:0]             end_reg, end_next;
    logic [1:0]              status_reg, status_next;
    logic                    two_reg, two_next;
    logic                    pos_br_reg, pos_br_next;

    // datapath registers, no reset
    logic [MANT_W-1:0]       norm_reg, norm_next;
    logic [SH_W-1:0]         shift_reg, shift_next;
    logic [SIG_W-1:0]        a_sig_reg, a_sig_next;
    logic [8:0]              a_exp_reg, a_exp_next;
    logic [5:0]              idx_reg, idx_next;
    logic [3:0]              idx1_reg, idx1_next;
    logic [2*SIG_W-1:0]      prod_reg, prod_next;
    logic signed [10:0]      es_reg, es_next;

    // character decode
    logic                    ch_fire;
    logic                    is_digit;
    logic [7:0]              ch_off;
    logic [3:0]              dval;

    // digit accumulation
    logic [MANT_W-1:0]       mul10;
    logic [MANT_W-1:0]       mc_mant;
    logic [3:0]              mc_sig;
    logic signed [15:0]      mc_exp;
    logic                    mc_point;
    logic [9:0]              ed_next;
    logic signed [17:0]      dec18;
    logic signed [17:0]      ed18;
    logic signed [17:0]      dx;
    logic signed [15:0]      dec_final;

    // end offset
    logic [OFFSET_BITS:0]    end_raw;
    logic [OFFSET_BITS-1:0]  end_sat;
    logic [32:0]             end_w;

    // decide
    logic [3:0]              sig9;
    logic signed [17:0]      e_plus;
    logic signed [17:0]      mag;
    logic signed [17:0]      k_raw;
    logic [5:0]              k_clamp;

    // convert
    logic [SIG_W-1:0]        c_sig;
    logic                    c_g;
    logic                    c_st;
    logic [SIG_W:0]          c_r;

    // multiply and round
    logic [31:0]             b_bits;
    logic [SIG_W-1:0]        rs;
    logic                    rg;
    logic                    rst_b;
    logic signed [10:0]      re;
    logic signed [10:0]      re2;
    logic [SIG_W:0]          rr;
    logic [30:0]             res;

    assign ch_stall    = (state_reg != S_SCAN) || out_valid_reg;
    assign ch_fire     = ch_valid && !ch_stall;
    assign res_valid   = out_valid_reg;
    assign result_bits = bits_reg;
    assign end_offset  = end_reg;
    assign status      = status_reg;

    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign ch_off   = ch - CH_ZERO;
    assign dval     = ch_off[3:0];

    // one significant digit or a point
    always_comb
    begin
        mul10    = MANT_W'({mant_reg, 3'b000}) + MANT_W'({mant_reg, 1'b0}) + MANT_W'(dval);
        mc_mant  = mant_reg;
        mc_sig   = sig_cnt_reg;
        mc_exp   = dec_exp_reg;
        mc_point = point_reg;
        if (ch == CH_DOT)
        begin
            mc_point = 1'b1;
        end
        else if (sig_cnt_reg < SIG_LIM)
        begin
            mc_mant = mul10;
            if (mul10 != '0)
            begin
                mc_sig = sig_cnt_reg + 4'd1;
            end
            if (point_reg && dec_exp_reg != DEC_MIN)
            begin
                mc_exp = dec_exp_reg - 16'sd1;
            end
        end
        else if (!point_reg && dec_exp_reg != DEC_MAX)
        begin
            mc_exp = dec_exp_reg + 16'sd1;
        end
    end

    // exponent digits stop growing once they reach 100
    assign ed_next = (exp_dig_reg < 10'd100)
                   ? 10'({exp_dig_reg, 3'b000} + {2'b00, exp_dig_reg, 1'b0} + 13'(dval))
                   : exp_dig_reg;

    always_comb
    begin
        dec18 = 18'(dec_exp_reg);
        ed18  = $signed({8'b0, exp_dig_reg});
        dx    = exp_neg_reg ? dec18 - ed18 : dec18 + ed18;
        if (dx > 18'sd32767)
        begin
            dec_final = DEC_MAX;
        end
        else if (dx < -18'sd32768)
        begin
            dec_final = DEC_MIN;
        end
        else
        begin
            dec_final = dx[15:0];
        end
    end

    assign end_sat = (end_raw > {1'b0, POS_MAX}) ? POS_MAX : end_raw[OFFSET_BITS-1:0];
    assign end_w   = 33'(end_sat);

    always_comb
    begin
        sig9    = (sig_cnt_reg > 4'd9) ? 4'd9 : sig_cnt_reg;
        e_plus  = 18'(dec_exp_reg) + $signed({14'b0, sig9});
        mag     = e_plus - 18'sd1;
        k_raw   = (dec_exp_reg < -16'sd37) ? -e_plus : -18'(dec_exp_reg);
        if (k_raw > 18'sd37)
        begin
            k_clamp = 6'd37;
        end
        else if (k_raw < 18'sd0)
        begin
            k_clamp = 6'd0;
        end
        else
        begin
            k_clamp = k_raw[5:0];
        end
    end

    always_comb
    begin
        c_sig = norm_reg[MANT_W-1 -: SIG_W];
        c_g   = norm_reg[MANT_W-SIG_W-1];
        c_st  = |norm_reg[MANT_W-SIG_W-2:0];
        c_r   = {1'b0, c_sig} + (SIG_W+1)'(c_g & (c_st | c_sig[0]));
    end

    always_comb
    begin
        if (two_reg)
        begin
            b_bits = NEG_TAB[32*int'(idx1_reg) +: 32];
        end
        else if (pos_br_reg)
        begin
            b_bits = POS_TAB[32*int'(idx_reg) +: 32];
        end
        else
        begin
            b_bits = NEG_TAB[32*int'(idx_reg) +: 32];
        end
    end

    // round the registered product to nearest even, flush below normal
    always_comb
    begin
        if (prod_reg[2*SIG_W-1])
        begin
            rs    = prod_reg[2*SIG_W-1 -: SIG_W];
            rg    = prod_reg[SIG_W-1];
            rst_b = |prod_reg[SIG_W-2:0];
            re    = es_reg + 11'sd1;
        end
        else
        begin
            rs    = prod_reg[2*SIG_W-2 -: SIG_W];
            rg    = prod_reg[SIG_W-2];
            rst_b = |prod_reg[SIG_W-3:0];
            re    = es_reg;
        end
        rr  = {1'b0, rs} + (SIG_W+1)'(rg & (rst_b | rs[0]));
        re2 = rr[SIG_W] ? re + 11'sd1 : re;
        if (re >= 11'sd1)
        begin
            if (re2 >= 11'sd255)
            begin
                res = F32_INF[30:0];
            end
            else
            begin
                res = {re2[7:0], (rr[SIG_W] ? 23'd0 : rr[22:0])};
            end
        end
        else if (re == 11'sd0 && (&rs))
        begin
            // rounds up to the smallest normal
            res = 31'h0080_0000;
        end
        else
        begin
            res = '0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        mant_next      = mant_reg;
        sig_cnt_next   = sig_cnt_reg;
        dec_exp_next   = dec_exp_reg;
        neg_next       = neg_reg;
        point_next     = point_reg;
        exp_dig_next   = exp_dig_reg;
        exp_neg_next   = exp_neg_reg;
        pos_next       = pos_reg;
        inf_next       = inf_reg;
        term_next      = term_reg;
        out_valid_next = out_valid_reg && res_stall;
        bits_next      = bits_reg;
        end_next       = end_reg;
        status_next    = status_reg;
        two_next       = two_reg;
        pos_br_next    = pos_br_reg;
        norm_next      = norm_reg;
        shift_next     = shift_reg;
        a_sig_next     = a_sig_reg;
        a_exp_next     = a_exp_reg;
        idx_next       = idx_reg;
        idx1_next      = idx1_reg;
        prod_next      = prod_reg;
        es_next        = es_reg;
        end_raw        = '0;

        unique case (state_reg)
            S_SCAN:
            begin
                if (ch_fire)
                begin
                    pos_next  = (pos_reg != POS_MAX) ? pos_reg + 1'b1 : pos_reg;
                    term_next = (ch == CH_NUL);
                    unique case (phase_reg) inside
                        PH_SPACES, PH_AFTER_SIGN:
                        begin
                            if (phase_reg == PH_SPACES && ch == CH_SPACE)
                            begin
                                // skip leading space
                                phase_next = PH_SPACES;
                            end
                            else if (phase_reg == PH_SPACES && ch == CH_PLUS)
                            begin
                                phase_next = PH_AFTER_SIGN;
                            end
                            else if (phase_reg == PH_SPACES && ch == CH_MINUS)
                            begin
                                neg_next   = 1'b1;
                                phase_next = PH_AFTER_SIGN;
                            end
                            else if (ch == CH_LI || ch == CH_UI)
                            begin
                                phase_next = PH_INF;
                                inf_next   = 2'd1;
                            end
                            else if (is_digit || ch == CH_DOT)
                            begin
                                phase_next   = PH_MANT;
                                mant_next    = mc_mant;
                                sig_cnt_next = mc_sig;
                                dec_exp_next = mc_exp;
                                point_next   = mc_point;
                            end
                            else
                            begin
                                bits_next      = '0;
                                end_next       = '0;
                                status_next    = ST_NONE;
                                out_valid_next = 1'b1;
                                phase_next     = PH_DONE;
                            end
                        end
                        PH_INF:
                        begin
                            if (inf_reg == 2'd1 && (ch == CH_LN || ch == CH_UN))
                            begin
                                inf_next = 2'd2;
                            end
                            else if (inf_reg == 2'd2 && (ch == CH_LF || ch == CH_UF))
                            begin
                                end_raw        = {1'b0, pos_reg} + 1'b1;
                                bits_next      = {neg_reg, F32_INF[30:0]};
                                end_next       = end_w[15:0];
                                status_next    = ST_OK;
                                out_valid_next = 1'b1;
                                phase_next     = PH_DONE;
                            end
                            else
                            begin
                                bits_next      = '0;
                                end_next       = '0;
                                status_next    = ST_NONE;
                                out_valid_next = 1'b1;
                                phase_next     = PH_DONE;
                            end
                        end
                        PH_MANT:
                        begin
                            if (is_digit || (ch == CH_DOT && !point_reg))
                            begin
                                mant_next    = mc_mant;
                                sig_cnt_next = mc_sig;
                                dec_exp_next = mc_exp;
                                point_next   = mc_point;
                            end
                            else if (ch == CH_LE || ch == CH_UE)
                            begin
                                phase_next = PH_EXP_START;
                            end
                            else
                            begin
                                end_raw    = {1'b0, pos_reg};
                                end_next   = end_w[15:0];
                                state_next = S_PREP;
                            end
                        end
                        PH_EXP_START:
                        begin
                            if (ch == CH_PLUS || ch == CH_MINUS)
                            begin
                                exp_neg_next = (ch == CH_MINUS);
                                phase_next   = PH_EXP_SIGN;
                            end
                            else if (is_digit)
                            begin
                                exp_dig_next = ed_next;
                                phase_next   = PH_EXP_DIGITS;
                            end
                            else
                            begin
                                end_raw    = {1'b0, pos_reg};
                                end_next   = end_w[15:0];
                                state_next = S_PREP;
                            end
                        end
                        PH_EXP_SIGN:
                        begin
                            if (is_digit)
                            begin
                                exp_dig_next = ed_next;
                                phase_next   = PH_EXP_DIGITS;
                            end
                            else
                            begin
                                // drop the sign from the consumed count
                                end_raw    = {1'b0, pos_reg} - 1'b1;
                                end_next   = end_w[15:0];
                                state_next = S_PREP;
                            end
                        end
                        PH_EXP_DIGITS:
                        begin
                            if (is_digit)
                            begin
                                exp_dig_next = ed_next;
                            end
                            else
                            begin
                                dec_exp_next = dec_final;
                                end_raw      = {1'b0, pos_reg};
                                end_next     = end_w[15:0];
                                state_next   = S_PREP;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_DONE;
                        end
                    endcase

                    // a terminator that closes or follows a result opens a new string
                    if (ch == CH_NUL && (out_valid_next || phase_reg == PH_DONE))
                    begin
                        phase_next   = PH_SPACES;
                        mant_next    = '0;
                        sig_cnt_next = '0;
                        dec_exp_next = '0;
                        neg_next     = 1'b0;
                        point_next   = 1'b0;
                        exp_dig_next = '0;
                        exp_neg_next = 1'b0;
                        pos_next     = '0;
                        inf_next     = '0;
                    end
                end
            end
            S_PREP:
            begin
                norm_next  = mant_reg;
                shift_next = '0;
                two_next   = 1'b0;
                idx1_next  = sig9;
                idx_next   = k_clamp;
                if (mant_reg == '0)
                begin
                    bits_next      = {neg_reg, 31'd0};
                    status_next    = ST_OK;
                    out_valid_next = 1'b1;
                    state_next     = S_SCAN;
                end
                else if (mag > 18'sd38 || mag < -18'sd38)
                begin
                    bits_next      = {neg_reg, 31'd0};
                    status_next    = ST_RANGE;
                    out_valid_next = 1'b1;
                    state_next     = S_SCAN;
                end
                else if (dec_exp_reg >= 16'sd0)
                begin
                    pos_br_next = 1'b1;
                    idx_next    = dec_exp_reg[5:0];
                    state_next  = S_NORM;
                end
                else
                begin
                    pos_br_next = 1'b0;
                    two_next    = (dec_exp_reg < -16'sd37);
                    state_next  = S_NORM;
                end
                if (state_next == S_SCAN)
                begin
                    phase_next = PH_DONE;
                    if (term_reg)
                    begin
                        phase_next   = PH_SPACES;
                        mant_next    = '0;
                        sig_cnt_next = '0;
                        dec_exp_next = '0;
                        neg_next     = 1'b0;
                        point_next   = 1'b0;
                        exp_dig_next = '0;
                        exp_neg_next = 1'b0;
                        pos_next     = '0;
                        inf_next     = '0;
                    end
                end
            end
            S_NORM:
            begin
                // advance one bit a cycle until the leading one reaches the top
                if (norm_reg[MANT_W-1])
                begin
                    state_next = S_CVT;
                end
                else
                begin
                    norm_next  = {norm_reg[MANT_W-2:0], 1'b0};
                    shift_next = shift_reg + 1'b1;
                end
            end
            S_CVT:
            begin
                if (c_r[SIG_W])
                begin
                    a_sig_next = {1'b1, {(SIG_W-1){1'b0}}};
                    a_exp_next = CVT_BIAS - 9'(shift_reg) + 9'd1;
                end
                else
                begin
                    a_sig_next = c_r[SIG_W-1:0];
                    a_exp_next = CVT_BIAS - 9'(shift_reg);
                end
                state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next  = (2*SIG_W)'(a_sig_reg) * (2*SIG_W)'({1'b1, b_bits[22:0]});
                es_next    = $signed({2'b00, a_exp_reg}) + $signed({3'b000, b_bits[30:23]})
                           - 11'sd127;
                state_next = S_RND;
            end
            S_RND:
            begin
                if (two_reg)
                begin
                    a_sig_next = {1'b1, res[22:0]};
                    a_exp_next = {1'b0, res[30:23]};
                    two_next   = 1'b0;
                    state_next = S_MUL;
                end
                else
                begin
                    if (res[30:23] == 8'hFF || res[30:23] == 8'h00)
                    begin
                        bits_next   = {neg_reg, 31'd0};
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        bits_next   = {neg_reg, res};
                        status_next = ST_OK;
                    end
                    out_valid_next = 1'b1;
                    state_next     = S_SCAN;
                    phase_next     = PH_DONE;
                    if (term_reg)
                    begin
                        phase_next   = PH_SPACES;
                        mant_next    = '0;
                        sig_cnt_next = '0;
                        dec_exp_next = '0;
                        neg_next     = 1'b0;
                        point_next   = 1'b0;
                        exp_dig_next = '0;
                        exp_neg_next = 1'b0;
                        pos_next     = '0;
                        inf_next     = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_SCAN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SCAN;
            phase_reg     <= PH_SPACES;
            mant_reg      <= '0;
            sig_cnt_reg   <= '0;
            dec_exp_reg   <= '0;
            neg_reg       <= 1'b0;
            point_reg     <= 1'b0;
            exp_dig_reg   <= '0;
            exp_neg_reg   <= 1'b0;
            pos_reg       <= '0;
            inf_reg       <= '0;
            term_reg      <= 1'b0;
            two_reg       <= 1'b0;
            pos_br_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            bits_reg      <= '0;
            end_reg       <= '0;
            status_reg    <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            mant_reg      <= mant_next;
            sig_cnt_reg   <= sig_cnt_next;
            dec_exp_reg   <= dec_exp_next;
            neg_reg       <= neg_next;
            point_reg     <= point_next;
            exp_dig_reg   <= exp_dig_next;
            exp_neg_reg   <= exp_neg_next;
            pos_reg       <= pos_next;
            inf_reg       <= inf_next;
            term_reg      <= term_next;
            two_reg       <= two_next;
            pos_br_reg    <= pos_br_next;
            out_valid_reg <= out_valid_next;
            bits_reg      <= bits_next;
            end_reg       <= end_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        norm_reg  <= norm_next;
        shift_reg <= shift_next;
        a_sig_reg <= a_sig_next;
        a_exp_reg <= a_exp_next;
        idx_reg   <= idx_next;
        idx1_reg  <= idx1_next;
        prod_reg  <= prod_next;
        es_reg    <= es_next;
    end

    `DSF_ASSERT_NOW(a_norm_nonzero, state_reg == S_NORM, norm_reg != '0)
    `DSF_ASSERT_NOW(a_no_result_in_conv, state_reg != S_SCAN, !out_valid_reg)
    `DSF_ASSERT_NOW(a_sig_bounded, 1'b1, sig_cnt_reg <= SIG_LIM)
    `DSF_ASSERT_NOW(a_status_code, out_valid_reg, status_reg <= ST_RANGE)
    `DSF_ASSERT_NEXT(a_done_holds, ch_fire && phase_reg == PH_DONE && ch != CH_NUL, phase_reg == PH_DONE && !out_valid_reg)

endmodule

>>> tb/dsf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsf_checker
// Watches the character and result channels of the converter, predicts each
// conversion from the accepted characters and compares every result transfer
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module dsf_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        ch_valid,
    input  logic        ch_stall,
    input  logic [7:0]  ch,
    input  logic        res_valid,
    input  logic        res_stall,
    input  logic [31:0] result_bits,
    input  logic [15:0] end_offset,
    input  logic [1:0]  status,
    output int          errors,
    output int          pending
);
    import dsf_pkg::*;

    localparam int SIG_LIMIT = 8;
    localparam int POS_LIMIT = 65535;

    typedef enum logic [2:0] {
        SCAN_SPACES, SCAN_SIGNED, SCAN_INF, SCAN_MANT,
        SCAN_EXP_START, SCAN_EXP_SIGN, SCAN_EXP_DIGITS, SCAN_DONE
    } scan_t;

    typedef struct packed {
        logic [31:0] bits;
        logic [15:0] offset;
        logic [1:0]  st;
    } conv_t;

    conv_t       conv_q[$];
    logic [31:0] pow_up[39];
    logic [31:0] pow_down[38];

    scan_t       scan;
    logic [31:0] mant;
    int          sig_cnt;
    int          dec_exp;
    bit          neg;
    bit          point_seen;
    int          exp_val;
    bit          exp_neg;
    int          char_pos;
    int          inf_cnt;

    // Round m * 2^s to binary32 (positive), nearest even, gradual underflow
    function automatic logic [31:0] round_f32(logic [255:0] m, int s, bit sticky_in);
        int           p;
        int           e;
        int           sh;
        int           i;
        logic [255:0] r;
        bit           guard;
        bit           stk;
        bit           normal;
        p = 0;
        for (i = 0; i < 256; i++)
        begin
            if (m[i])
            begin
                p = i;
            end
        end
        e      = p + s;
        normal = (e + 127 >= 1);
        sh     = normal ? p - 23 : -149 - s;
        if (sh <= 0)
        begin
            r = m << (-sh);
        end
        else
        begin
            r     = m >> sh;
            guard = m[sh-1];
            stk   = ((m & ((256'd1 << (sh - 1)) - 256'd1)) != '0) || sticky_in;
            if (guard && (stk || r[0]))
            begin
                r = r + 256'd1;
            end
        end
        if (!normal)
        begin
            return r[31:0];
        end
        if (r[24])
        begin
            r = r >> 1;
            e = e + 1;
        end
        if (e + 127 >= 255)
        begin
            return F32_INF;
        end
        return {1'b0, 8'(e + 127), r[22:0]};
    endfunction

    function automatic logic [31:0] mul_f32(logic [31:0] a, logic [31:0] b);
        logic [255:0] ma;
        logic [255:0] mb;
        int           ea;
        int           eb;
        ma = (a[30:23] != 0) ? {1'b1, a[22:0]} : {1'b0, a[22:0]};
        mb = (b[30:23] != 0) ? {1'b1, b[22:0]} : {1'b0, b[22:0]};
        ea = (a[30:23] != 0) ? int'(a[30:23]) : 1;
        eb = (b[30:23] != 0) ? int'(b[30:23]) : 1;
        if (ma == '0 || mb == '0)
        begin
            return 32'h0;
        end
        return round_f32(ma * mb, ea + eb - 300, 1'b0);
    endfunction

    function automatic int clamp16(int v);
        if (v > 32767)
        begin
            return 32767;
        end
        if (v < -32768)
        begin
            return -32768;
        end
        return v;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    task automatic clear_string();
        scan       = SCAN_SPACES;
        mant       = 0;
        sig_cnt    = 0;
        dec_exp    = 0;
        neg        = 0;
        point_seen = 0;
        exp_val    = 0;
        exp_neg    = 0;
        char_pos   = 0;
        inf_cnt    = 0;
    endtask

    task automatic push_result(logic [31:0] bits, int offset, logic [1:0] st,
                               logic [7:0] c);
        conv_t r;
        r.bits   = bits;
        r.offset = 16'((offset > POS_LIMIT) ? POS_LIMIT : offset);
        r.st     = st;
        conv_q.push_back(r);
        if (c == CH_NUL)
        begin
            clear_string();
        end
        else
        begin
            scan = SCAN_DONE;
        end
    endtask

    task automatic convert_number(int offset, logic [7:0] c);
        logic [31:0] bits;
        logic [1:0]  st;
        int          e;
        int          sig;
        int          k;
        int          mag;
        bits = 0;
        st   = ST_OK;
        e    = dec_exp;
        sig  = (sig_cnt > 9) ? 9 : sig_cnt;
        if (mant != 0)
        begin
            mag = e + sig - 1;
            if (mag > 38 || mag < -38)
            begin
                st = ST_RANGE;
            end
            else if (e >= 0)
            begin
                if (e > 38)
                begin
                    e = 38;
                end
                bits = mul_f32(round_f32(256'(mant), 0, 1'b0), pow_up[e]);
                if ((bits & 32'h7FFF_FFFF) == F32_INF)
                begin
                    bits = 0;
                    st   = ST_RANGE;
                end
            end
            else
            begin
                bits = round_f32(256'(mant), 0, 1'b0);
                // Split very small scales into two multiplies
                if (e < -37)
                begin
                    bits = mul_f32(bits, pow_down[sig]);
                    e    = e + sig;
                end
                k = -e;
                if (k > 37)
                begin
                    k = 37;
                end
                if (k < 0)
                begin
                    k = 0;
                end
                bits = mul_f32(bits, pow_down[k]);
                if (bits[30:23] == 0)
                begin
                    bits = 0;
                end
                if (bits == 0)
                begin
                    st = ST_RANGE;
                end
            end
        end
        if (neg)
        begin
            bits = bits ^ 32'h8000_0000;
        end
        push_result(bits, offset, st, c);
    endtask

    task automatic take_mant(logic [7:0] c);
        if (c == CH_DOT)
        begin
            point_seen = 1;
        end
        else if (sig_cnt < SIG_LIMIT)
        begin
            mant = mant * 10 + 32'(c - CH_ZERO);
            if (mant != 0)
            begin
                sig_cnt++;
            end
            if (point_seen)
            begin
                dec_exp = clamp16(dec_exp - 1);
            end
        end
        else if (!point_seen)
        begin
            dec_exp = clamp16(dec_exp + 1);
        end
    endtask

    task automatic take_exp(logic [7:0] c);
        if (exp_val < 100)
        begin
            exp_val = exp_val * 10 + int'(c - CH_ZERO);
        end
    endtask

    task automatic scan_char(logic [7:0] c);
        int  pos;
        bit  lead;
        pos  = char_pos;
        lead = 0;
        if (char_pos < POS_LIMIT)
        begin
            char_pos++;
        end
        case (scan)
            SCAN_SPACES:
            begin
                if (c == CH_PLUS)
                begin
                    scan = SCAN_SIGNED;
                end
                else if (c == CH_MINUS)
                begin
                    neg  = 1;
                    scan = SCAN_SIGNED;
                end
                else if (c != CH_SPACE)
                begin
                    lead = 1;
                end
            end
            SCAN_SIGNED:
            begin
                lead = 1;
            end
            SCAN_INF:
            begin
                if (inf_cnt == 1 && (c == CH_LN || c == CH_UN))
                begin
                    inf_cnt = 2;
                end
                else if (inf_cnt == 2 && (c == CH_LF || c == CH_UF))
                begin
                    push_result(neg ? 32'hFF80_0000 : F32_INF, pos + 1, ST_OK, c);
                end
                else
                begin
                    push_result(0, 0, ST_NONE, c);
                end
            end
            SCAN_MANT:
            begin
                if (is_digit(c) || (c == CH_DOT && !point_seen))
                begin
                    take_mant(c);
                end
                else if (c == CH_LE || c == CH_UE)
                begin
                    scan = SCAN_EXP_START;
                end
                else
                begin
                    convert_number(pos, c);
                end
            end
            SCAN_EXP_START:
            begin
                if (c == CH_PLUS || c == CH_MINUS)
                begin
                    exp_neg = (c == CH_MINUS);
                    scan    = SCAN_EXP_SIGN;
                end
                else if (is_digit(c))
                begin
                    take_exp(c);
                    scan = SCAN_EXP_DIGITS;
                end
                else
                begin
                    convert_number(pos, c);
                end
            end
            SCAN_EXP_SIGN:
            begin
                if (is_digit(c))
                begin
                    take_exp(c);
                    scan = SCAN_EXP_DIGITS;
                end
                else
                begin
                    convert_number(pos - 1, c);
                end
            end
            SCAN_EXP_DIGITS:
            begin
                if (is_digit(c))
                begin
                    take_exp(c);
                end
                else
                begin
                    dec_exp = clamp16(exp_neg ? dec_exp - exp_val : dec_exp + exp_val);
                    convert_number(pos, c);
                end
            end
            default:
            begin
                // drop everything up to the terminator
                if (c == CH_NUL)
                begin
                    clear_string();
                end
            end
        endcase
        if (lead)
        begin
            if (c == CH_LI || c == CH_UI)
            begin
                scan    = SCAN_INF;
                inf_cnt = 1;
            end
            else if (is_digit(c) || c == CH_DOT)
            begin
                scan = SCAN_MANT;
                take_mant(c);
            end
            else
            begin
                push_result(0, 0, ST_NONE, c);
            end
        end
    endtask

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $time, field, got, want);
        errors++;
    endtask

    initial
    begin : build_tables
        logic [255:0] ten_k;
        int           k;
        errors  = 0;
        pending = 0;
        clear_string();
        ten_k = 256'd1;
        for (k = 0; k < 39; k++)
        begin
            pow_up[k] = round_f32(ten_k, 0, 1'b0);
            if (k < 38)
            begin
                pow_down[k] = round_f32((256'd1 << 200) / ten_k, -200,
                                        ((256'd1 << 200) % ten_k) != '0);
            end
            ten_k = ten_k * 256'd10;
        end
    end

    always @(posedge clk)
    begin : watch
        conv_t want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (conv_q.size() == 0)
                begin
                    $display("%0t: result transfer with nothing predicted", $time);
                    errors++;
                end
                else
                begin
                    want = conv_q.pop_front();
                    if (result_bits !== want.bits)
                    begin
                        report("result_bits", result_bits, want.bits);
                    end
                    if (end_offset !== want.offset)
                    begin
                        report("end_offset", 32'(end_offset), 32'(want.offset));
                    end
                    if (status !== want.st)
                    begin
                        report("status", 32'(status), 32'(want.st));
                    end
                end
            end
            if (ch_valid && !ch_stall)
            begin
                scan_char(ch);
            end
            pending = conv_q.size();
        end
    end

endmodule

>>> tb/decimal_string_to_float_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_string_to_float_top_test
// Feeds directed and random strings to the converter with random gaps and
// receiver stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module decimal_string_to_float_top_test;
    import dsf_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int RAND_CHARS = 1700;

    logic        clk;
    logic        rst_n;
    logic        ch_valid;
    logic        ch_stall;
    logic [7:0]  ch;
    logic        res_valid;
    logic        res_stall;
    logic [31:0] result_bits;
    logic [15:0] end_offset;
    logic [1:0]  status;
    int          errors;
    int          pending;
    int          idle_cycles;
    logic [7:0]  char_q[$];

    decimal_string_to_float_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .ch_valid    (ch_valid),
        .ch_stall    (ch_stall),
        .ch          (ch),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .result_bits (result_bits),
        .end_offset  (end_offset),
        .status      (status)
    );

    dsf_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .ch_valid    (ch_valid),
        .ch_stall    (ch_stall),
        .ch          (ch),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .result_bits (result_bits),
        .end_offset  (end_offset),
        .status      (status),
        .errors      (errors),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    task automatic add_string(string s);
        int i;
        for (i = 0; i < s.len(); i++)
        begin
            char_q.push_back(s[i]);
        end
        char_q.push_back(CH_NUL);
    endtask

    task automatic add_repeat(logic [7:0] c, int n);
        int i;
        for (i = 0; i < n; i++)
        begin
            char_q.push_back(c);
        end
    endtask

    function automatic logic [7:0] any_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_case(logic [7:0] lo, logic [7:0] hi);
        return $urandom_range(0, 1) ? lo : hi;
    endfunction

    // Mostly well-formed numbers with random content, some noise
    task automatic add_random_string();
        int i;
        int n;
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 12);
            for (i = 0; i < n; i++)
            begin
                char_q.push_back(8'($urandom_range(0, 255)));
            end
            char_q.push_back(CH_NUL);
            return;
        end
        add_repeat(CH_SPACE, $urandom_range(0, 2) == 0 ? $urandom_range(1, 4) : 0);
        case ($urandom_range(0, 2))
            0: char_q.push_back(CH_PLUS);
            1: char_q.push_back(CH_MINUS);
            default: ;
        endcase
        if ($urandom_range(0, 11) == 0)
        begin
            char_q.push_back(pick_case(CH_LI, CH_UI));
            if ($urandom_range(0, 3) != 0)
            begin
                char_q.push_back(pick_case(CH_LN, CH_UN));
            end
            char_q.push_back(pick_case(CH_LF, CH_UF));
        end
        else
        begin
            add_repeat(CH_ZERO, $urandom_range(0, 3) == 0 ? $urandom_range(1, 5) : 0);
            n = $urandom_range(0, 11);
            for (i = 0; i < n; i++)
            begin
                char_q.push_back(any_digit());
            end
            if ($urandom_range(0, 1))
            begin
                char_q.push_back(CH_DOT);
                n = $urandom_range(0, 10);
                for (i = 0; i < n; i++)
                begin
                    char_q.push_back(any_digit());
                end
            end
            if ($urandom_range(0, 2) != 0)
            begin
                char_q.push_back(pick_case(CH_LE, CH_UE));
                case ($urandom_range(0, 3))
                    0: char_q.push_back(CH_PLUS);
                    1, 2: char_q.push_back(CH_MINUS);
                    default: ;
                endcase
                n = $urandom_range(0, 4);
                for (i = 0; i < n; i++)
                begin
                    char_q.push_back(any_digit());
                end
            end
        end
        // Trail off with junk that must be skipped up to the terminator
        if ($urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++)
            begin
                char_q.push_back(8'($urandom_range(1, 255)));
            end
        end
        char_q.push_back(CH_NUL);
    endtask

    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 95)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    initial
    begin : stimulus
        int gap;
        rst_n    = 1'b0;
        ch_valid = 1'b0;
        ch       = '0;
        add_string("");
        add_string("   ");
        add_string("  +42");
        add_string("-0");
        add_string("inf");
        add_string("-InF");
        add_string("iNx");
        add_string("i");
        add_string(".");
        add_string("-.e5");
        add_string("1.2.3");
        add_string("7e");
        add_string("7e+");
        add_string("7E-q");
        add_string("3.4028234e38");
        add_string("3.5e38");
        add_string("1.1754944e-38");
        add_string("9e-39");
        add_string("123456789012.5e-3");
        add_string("0.0000000001234e-30");
        add_string("1e999 tail");
        add_string("-1e-999");
        add_string("abc");
        add_string("1e+999");
        while (char_q.size() < RAND_CHARS)
        begin
            add_random_string();
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (char_q.size() > 0)
        begin
            gap = next_gap();
            if (gap > 0)
            begin
                ch_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            ch_valid <= 1'b1;
            ch       <= char_q.pop_front();
            do
            begin
                @(posedge clk);
            end
            while (ch_stall);
        end
        ch_valid <= 1'b0;
        // let the checker take the last transfer before looking at pending
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (60) @(posedge clk);
        if (errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial
    begin : receiver
        int n;
        res_stall = 1'b1;
        @(posedge rst_n);
        // hold off long so the block fills up and stalls its input
        repeat (500) @(posedge clk);
        forever
        begin
            res_stall <= 1'b0;
            n = $urandom_range(0, 7) == 0 ? $urandom_range(50, 200) : $urandom_range(1, 20);
            repeat (n) @(posedge clk);
            res_stall <= 1'b1;
            n = $urandom_range(0, 9) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 3);
            repeat (n) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (ch_valid && !ch_stall) || (res_valid && !res_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
